[hdl/rdc_pkg.sv]
// Shared types, constants and helpers for the radix digit converter.
`default_nettype none
package rdc_pkg;

  localparam int FRAC_DIGITS_DEF = 30;
  localparam int INT_WIDTH_DEF   = 31;
  localparam int FRAC_WIDTH_DEF  = 32;
  localparam int INT_W_MAX       = 31;
  localparam int FRAC_W_MAX      = 32;
  localparam int RADIX_W         = 5;
  localparam int DIGIT_W         = 4;
  localparam int KIND_W          = 2;
  localparam int DIV_STEPS       = 8;
  localparam int QDEPTH          = 2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [KIND_W-1:0] KIND_INT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FRAC  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } state_t;

  typedef struct packed {
    logic                  frac_nz;
    logic [INT_W_MAX-1:0]  whole;
    logic [FRAC_W_MAX-1:0] frac;
  } desc_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] v;
    begin
      v = r;
      if (r < RADIX_MIN) v = RADIX_MIN;
      if (r > RADIX_MAX) v = RADIX_MAX;
      return v;
    end
  endfunction

endpackage
`default_nettype wire

[hdl/rdc_front.sv]
// Input stage: accepts words, masks the fields and flags a nonzero fraction.
`default_nettype none
module rdc_front #(
  parameter int INT_WIDTH  = rdc_pkg::INT_WIDTH_DEF,
  parameter int FRAC_WIDTH = rdc_pkg::FRAC_WIDTH_DEF,
  parameter int IN_W       = ((INT_WIDTH + FRAC_WIDTH + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [IN_W-1:0]     in_tdata,
  output logic                     push,
  output rdc_pkg::desc_t           push_desc,
  input  wire logic                q_full
);

  logic           valid_r, valid_nxt;
  rdc_pkg::desc_t desc_r, desc_nxt;
  logic [INT_WIDTH-1:0]  whole_in;
  logic [FRAC_WIDTH-1:0] frac_in;

  assign whole_in  = in_tdata[INT_WIDTH-1:0];
  assign frac_in   = in_tdata[INT_WIDTH+FRAC_WIDTH-1:INT_WIDTH];
  assign push      = valid_r && !q_full;
  assign push_desc = desc_r;
  assign in_tready = !valid_r || !q_full;

  always_comb begin
    valid_nxt = valid_r;
    desc_nxt  = desc_r;
    if (push) valid_nxt = 1'b0;
    if (in_tvalid && in_tready) begin
      valid_nxt        = 1'b1;
      desc_nxt.whole   = rdc_pkg::INT_W_MAX'(whole_in);
      desc_nxt.frac    = rdc_pkg::FRAC_W_MAX'(frac_in);
      desc_nxt.frac_nz = |frac_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    desc_r <= desc_nxt;
  end

endmodule
`default_nettype wire

[hdl/rdc_fifo.sv]
// Short descriptor queue between the input stage and the digit engine.
`default_nettype none
module rdc_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  rdc_pkg::desc_t      push_desc,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output rdc_pkg::desc_t      q_desc
);

  localparam int PW = $clog2(rdc_pkg::QDEPTH);
  localparam int CW = $clog2(rdc_pkg::QDEPTH + 1);

  rdc_pkg::desc_t mem_r [rdc_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_pop;

  assign full    = (count_r == CW'(rdc_pkg::QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_desc  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      if (push && !do_pop) count_r <= count_r + CW'(1);
      else if (!push && do_pop) count_r <= count_r - CW'(1);
    end
    if (push) mem_r[wr_ptr_r] <= push_desc;
  end

endmodule
`default_nettype wire

[hdl/rdc_back.sv]
// Digit engine: iterative radix division, digit stack, fraction multiply, output register.
`default_nettype none
module rdc_back #(
  parameter int FRAC_DIGITS = rdc_pkg::FRAC_DIGITS_DEF,
  parameter int INT_WIDTH   = rdc_pkg::INT_WIDTH_DEF,
  parameter int FRAC_WIDTH  = rdc_pkg::FRAC_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [rdc_pkg::RADIX_W-1:0]   radix,
  input  wire logic                          q_valid,
  input  rdc_pkg::desc_t                     q_desc,
  output logic                               pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [rdc_pkg::DIGIT_W-1:0]        out_digit,
  output logic [rdc_pkg::KIND_W-1:0]         out_kind,
  output logic                               out_last
);

  localparam int RW  = rdc_pkg::RADIX_W;
  localparam int DW  = rdc_pkg::DIGIT_W;
  localparam int CW  = $clog2(INT_WIDTH + rdc_pkg::DIV_STEPS + 1);
  localparam int SPW = $clog2(INT_WIDTH + 1);
  localparam int AW  = $clog2(INT_WIDTH);
  localparam int FCW = $clog2(FRAC_DIGITS + 1);

  rdc_pkg::state_t state_r, state_nxt;
  logic [INT_WIDTH-1:0]  quo_r, quo_nxt;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [SPW-1:0]        sp_r, sp_nxt;
  logic [FRAC_WIDTH-1:0] frac_r, frac_nxt;
  logic                  fnz_r, fnz_nxt;
  logic [FCW-1:0]        fcnt_r, fcnt_nxt;
  logic [DW-1:0]         stack_r [INT_WIDTH];
  logic                  push_dig;
  logic [DW-1:0]         push_val;
  logic [SPW-1:0]        sp_dec;
  logic                  ovalid_r, ovalid_nxt;
  logic [DW-1:0]         odigit_r, odigit_nxt;
  logic [rdc_pkg::KIND_W-1:0] okind_r, okind_nxt;
  logic                  olast_r, olast_nxt;
  logic                  take;
  logic [INT_WIDTH-1:0]  q_v;
  logic [RW-1:0]         r_v;
  logic [FRAC_WIDTH+RW-1:0] prod;
  logic [FRAC_WIDTH-1:0] fnew;
  logic                  flast;

  assign out_tvalid = ovalid_r;
  assign out_digit  = odigit_r;
  assign out_kind   = okind_r;
  assign out_last   = olast_r;
  assign take       = !ovalid_r || out_tready;
  assign sp_dec     = sp_r - SPW'(1);
  assign prod       = frac_r * (FRAC_WIDTH+RW)'(radix);
  assign fnew       = prod[FRAC_WIDTH-1:0];
  assign flast      = (fnew == '0) || (fcnt_r == FCW'(FRAC_DIGITS - 1));

  always_comb begin
    state_nxt  = state_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    sp_nxt     = sp_r;
    frac_nxt   = frac_r;
    fnz_nxt    = fnz_r;
    fcnt_nxt   = fcnt_r;
    ovalid_nxt = ovalid_r;
    odigit_nxt = odigit_r;
    okind_nxt  = okind_r;
    olast_nxt  = olast_r;
    pop        = 1'b0;
    push_dig   = 1'b0;
    q_v        = quo_r;
    r_v        = rem_r;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    for (int k = 0; k < rdc_pkg::DIV_STEPS; k++) begin
      if (int'(cnt_r) + k < INT_WIDTH) begin
        r_v = {r_v[RW-2:0], q_v[INT_WIDTH-1]};
        q_v = {q_v[INT_WIDTH-2:0], 1'b0};
        if (r_v >= radix) begin
          r_v    = r_v - radix;
          q_v[0] = 1'b1;
        end
      end
    end
    push_val = r_v[DW-1:0];
    unique case (state_r)
      rdc_pkg::ST_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          quo_nxt   = q_desc.whole[INT_WIDTH-1:0];
          frac_nxt  = q_desc.frac[FRAC_WIDTH-1:0];
          fnz_nxt   = q_desc.frac_nz;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          sp_nxt    = '0;
          state_nxt = rdc_pkg::ST_DIV;
        end
      end
      rdc_pkg::ST_DIV: begin
        quo_nxt = q_v;
        rem_nxt = r_v;
        cnt_nxt = cnt_r + CW'(rdc_pkg::DIV_STEPS);
        if (int'(cnt_r) + rdc_pkg::DIV_STEPS >= INT_WIDTH) begin
          push_dig = 1'b1;
          sp_nxt   = sp_r + SPW'(1);
          rem_nxt  = '0;
          cnt_nxt  = '0;
          if (q_v == '0) state_nxt = rdc_pkg::ST_INT;
        end
      end
      rdc_pkg::ST_INT: begin
        if (take) begin
          ovalid_nxt = 1'b1;
          odigit_nxt = stack_r[sp_dec[AW-1:0]];
          okind_nxt  = rdc_pkg::KIND_INT;
          olast_nxt  = (sp_r == SPW'(1)) && !fnz_r;
          sp_nxt     = sp_dec;
          if (sp_r == SPW'(1)) state_nxt = fnz_r ? rdc_pkg::ST_POINT : rdc_pkg::ST_IDLE;
        end
      end
      rdc_pkg::ST_POINT: begin
        if (take) begin
          ovalid_nxt = 1'b1;
          odigit_nxt = '0;
          okind_nxt  = rdc_pkg::KIND_POINT;
          olast_nxt  = 1'b0;
          fcnt_nxt   = '0;
          state_nxt  = rdc_pkg::ST_FRAC;
        end
      end
      rdc_pkg::ST_FRAC: begin
        if (take) begin
          ovalid_nxt = 1'b1;
          odigit_nxt = prod[FRAC_WIDTH+DW-1:FRAC_WIDTH];
          okind_nxt  = rdc_pkg::KIND_FRAC;
          olast_nxt  = flast;
          frac_nxt   = fnew;
          fcnt_nxt   = fcnt_r + FCW'(1);
          if (flast) state_nxt = rdc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rdc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rdc_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      sp_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      sp_r     <= sp_nxt;
    end
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    frac_r   <= frac_nxt;
    fnz_r    <= fnz_nxt;
    fcnt_r   <= fcnt_nxt;
    odigit_r <= odigit_nxt;
    okind_r  <= okind_nxt;
    olast_r  <= olast_nxt;
    if (push_dig) stack_r[sp_r[AW-1:0]] <= push_val;
  end

`ifndef SYNTH
  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rdc_pkg::ST_DIV |-> rem_r < radix)
    else $error("remainder not below radix");
  a_point_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && okind_r == rdc_pkg::KIND_POINT |-> !olast_r)
    else $error("point marked last");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(sp_r) <= INT_WIDTH)
    else $error("digit stack overflow");
  a_frac_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rdc_pkg::ST_FRAC |-> frac_r != '0)
    else $error("fraction exhausted but still emitting");
`endif

endmodule
`default_nettype wire

[hdl/radix_digit_converter_unit.sv]
// Path: each word passes the input register and the descriptor queue into the engine, which
// divides out all integer digits (iterative radix division) before it emits any word, then
// emits one word per cycle while out_tready allows. The engine takes one conversion at a time;
// the input register and the queue accept further words while it works.
// Reset: synchronous active-low rst_n empties queue and output, radix returns to 10.
// Top level of the radix digit converter.
`default_nettype none
module radix_digit_converter_unit #(
  parameter int FRAC_DIGITS = rdc_pkg::FRAC_DIGITS_DEF,
  parameter int INT_WIDTH   = rdc_pkg::INT_WIDTH_DEF,
  parameter int FRAC_WIDTH  = rdc_pkg::FRAC_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // integer_part, fraction_part
  input  wire logic [((INT_WIDTH + FRAC_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // digit
  output logic [7:0] out_tdata,
  // kind
  output logic [rdc_pkg::KIND_W-1:0] out_tuser,
  output logic      out_tlast,
  input  wire logic cfg_wr_en,
  input  wire logic [rdc_pkg::RADIX_W-1:0] cfg_wr_data
);

  logic [rdc_pkg::RADIX_W-1:0] radix_r;
  logic [rdc_pkg::RADIX_W-1:0] radix_eff;
  logic                        push, q_full, pop, q_valid;
  rdc_pkg::desc_t              push_desc, q_desc;
  logic [rdc_pkg::DIGIT_W-1:0] digit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rdc_pkg::RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  assign radix_eff = rdc_pkg::eff_radix(radix_r);
  assign out_tdata = 8'(digit);

  rdc_front #(
    .INT_WIDTH  (INT_WIDTH),
    .FRAC_WIDTH (FRAC_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full)
  );

  rdc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  rdc_back #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .INT_WIDTH   (INT_WIDTH),
    .FRAC_WIDTH  (FRAC_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .radix      (radix_eff),
    .q_valid    (q_valid),
    .q_desc     (q_desc),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_digit  (digit),
    .out_kind   (out_tuser),
    .out_last   (out_tlast)
  );

endmodule
`default_nettype wire
